// ----- hdl/paged_memory_map_decoder_assert.svh -----
// Assertion macros shared by the paged memory map decoder RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef PAGED_MEMORY_MAP_DECODER_ASSERT_SVH
`define PAGED_MEMORY_MAP_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PMMD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("paged memory map decoder: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PMMD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("paged memory map decoder: next-cycle check failed");

`endif

// ----- hdl/pmmd_pkg.sv -----
// Shared types and codes for the paged memory map decoder.
// No dependencies; used by pmmd_decode and paged_memory_map_decoder.
package pmmd_pkg;

  // Request modes.
  localparam logic [1:0] MODE_ACCESS  = 2'd0;
  localparam logic [1:0] MODE_MEM_PG  = 2'd1;
  localparam logic [1:0] MODE_WIN_PG  = 2'd2;

  // Decode targets.
  localparam logic [2:0] TGT_RAM  = 3'd0;
  localparam logic [2:0] TGT_ROM  = 3'd1;
  localparam logic [2:0] TGT_FDC  = 3'd2;
  localparam logic [2:0] TGT_DRV  = 3'd3;
  localparam logic [2:0] TGT_NONE = 3'd4;

  // Result of decoding one request.
  typedef struct packed {
    logic [2:0]  target;
    logic [16:0] location;
    logic        write_taken;
    logic [1:0]  ctrl_reg;
  } pmmd_result_t;

endpackage

// ----- hdl/pmmd_decode.sv -----
// Combinational address decoder over the fifteen memory regions.
// Depends on pmmd_pkg for the mode and target codes and the result type.
module pmmd_decode (
  input  logic [1:0]            mode,
  input  logic [15:0]           address,
  input  logic                  is_write,
  input  logic [3:0]            memory_page,
  input  logic [7:0]            window_page,
  output pmmd_pkg::pmmd_result_t result
);
  import pmmd_pkg::*;

  // Window page values with a special meaning.
  localparam logic [7:0] WP_DISK  = 8'd2;
  localparam logic [7:0] WP_TIMER = 8'd4;

  logic [16:0] a17;
  logic [16:0] win1;
  logic [16:0] win2;
  logic [16:0] o;
  logic [2:0]  tgt;
  logic [16:0] loc;
  logic [1:0]  reg_sel;
  logic        p7;

  // ROM image bases seen through the two windows.
  always_comb begin
    if (window_page == WP_DISK) begin
      win1 = 17'h16000;
    end else if (window_page == WP_TIMER) begin
      win1 = 17'h14000;
    end else begin
      win1 = 17'h10000;
    end
    win2 = (window_page == WP_TIMER) ? 17'h18000 : 17'h10000;
  end

  assign a17 = {1'b0, address};
  assign p7  = (memory_page == 4'd7);

  // Region decode; each region that needs an offset computes it from its own base.
  always_comb begin
    tgt     = TGT_NONE;
    loc     = '0;
    reg_sel = '0;
    o       = '0;
    if (mode == MODE_ACCESS) begin
      if (address < 16'h0800) begin
        if (memory_page == 4'd0) begin
          tgt = TGT_ROM;
          loc = 17'h10000 + a17;
        end else begin
          tgt = TGT_RAM;
          loc = p7 ? 17'h08000 + a17 : a17;
        end
      end else if (address < 16'h4000) begin
        tgt = TGT_RAM;
        loc = p7 ? 17'h08000 + a17 : a17;
      end else if (address < 16'h6000) begin
        o = a17 - 17'h04000;
        if (p7) begin
          tgt = TGT_RAM;
          loc = 17'h0c000 + o;
        end else if (memory_page == 4'd10) begin
          tgt = TGT_ROM;
          loc = win1 + o;
        end else begin
          tgt = TGT_RAM;
          loc = a17;
        end
      end else if (address < 16'h8000) begin
        o   = a17 - 17'h06000;
        tgt = TGT_RAM;
        loc = p7 ? 17'h0e000 + o : a17;
      end else if (address < 16'ha000) begin
        o = a17 - 17'h08000;
        if (memory_page == 4'd5 || memory_page == 4'd10) begin
          tgt = TGT_ROM;
          loc = win2 + o;
        end else if (memory_page == 4'd8 || memory_page == 4'd9) begin
          tgt = TGT_ROM;
          loc = win1 + o;
        end else begin
          tgt = TGT_RAM;
          loc = p7 ? o : a17;
        end
      end else if (address < 16'hb800) begin
        o = a17 - 17'h0a000;
        if (memory_page == 4'd5 || memory_page == 4'd10) begin
          tgt = TGT_ROM;
          loc = win2 + o;
        end else if (memory_page == 4'd6 || memory_page == 4'd8) begin
          tgt = TGT_ROM;
          loc = 17'h12000 + o;
        end else begin
          tgt = TGT_RAM;
          loc = p7 ? 17'h02000 + o : a17;
        end
      end else if (address < 16'hc000) begin
        o = a17 - 17'h0b800;
        if (memory_page == 4'd4 || memory_page == 4'd5 || memory_page == 4'd10) begin
          tgt = TGT_ROM;
          loc = win2 + 17'h01800 + o;
        end else if (memory_page == 4'd6 || memory_page == 4'd8) begin
          tgt = TGT_ROM;
          loc = 17'h13800 + o;
        end else begin
          tgt = TGT_RAM;
          loc = p7 ? 17'h03800 + o : a17;
        end
      end else if (address < 16'hc800) begin
        o = a17 - 17'h0c000;
        if (memory_page == 4'd8 || memory_page == 4'd10) begin
          tgt = TGT_ROM;
          loc = 17'h10000 + o;
        end else begin
          tgt = TGT_RAM;
          loc = p7 ? 17'h04000 + o : a17;
        end
      end else if (address < 16'hd000) begin
        o = a17 - 17'h0c800;
        if (memory_page == 4'd8 || memory_page == 4'd9) begin
          tgt = TGT_ROM;
          loc = win2 + o;
        end else if (memory_page == 4'd10) begin
          tgt = TGT_ROM;
          loc = 17'h10800 + o;
        end else begin
          tgt = TGT_RAM;
          loc = p7 ? 17'h04800 + o : a17;
        end
      end else if (address < 16'hd800) begin
        o = a17 - 17'h0d000;
        if (memory_page == 4'd8 || memory_page == 4'd9) begin
          tgt = TGT_ROM;
          loc = win2 + 17'h00800 + o;
        end else begin
          tgt = TGT_RAM;
          loc = p7 ? 17'h05000 + o : a17;
        end
      end else if (address < 16'hdc00) begin
        tgt = TGT_NONE;
      end else if (address < 16'hde00) begin
        // I/O window by window page: disk controller or drive control, no target for the timer page, or boot ROM.
        o = a17 - 17'h0dc00;
        if (window_page == WP_DISK) begin
          if (o < 17'h00100) begin
            tgt     = TGT_FDC;
            reg_sel = o[1:0];
          end else begin
            tgt = TGT_DRV;
          end
        end else if (window_page == WP_TIMER) begin
          tgt = TGT_NONE;
        end else begin
          tgt = TGT_ROM;
          loc = 17'h10000 + o;
        end
      end else if (address < 16'he000) begin
        tgt = TGT_NONE;
      end else if (address < 16'he800) begin
        o   = a17 - 17'h0e000;
        tgt = TGT_ROM;
        loc = ((memory_page == 4'd1) ? 17'h10000 : win1) + o;
      end else begin
        o   = a17 - 17'h0e800;
        tgt = TGT_ROM;
        if (memory_page == 4'd3 || memory_page == 4'd4 || memory_page == 4'd5) begin
          loc = win1 + 17'h00800 + o;
        end else begin
          loc = 17'h10800 + o;
        end
      end
    end
  end

  // Writes land only in RAM, the controller registers and drive control.
  always_comb begin
    result.target      = tgt;
    result.location    = loc;
    result.ctrl_reg    = reg_sel;
    result.write_taken = is_write && (tgt == TGT_RAM || tgt == TGT_FDC || tgt == TGT_DRV);
  end

endmodule

// ----- hdl/paged_memory_map_decoder.sv -----
// Top level of the paged memory map decoder: page registers and result register.
// Depends on pmmd_pkg, pmmd_decode and paged_memory_map_decoder_assert.svh.
//
// One request is accepted every clock while the input is not stalled, and its
// result appears in the output register in the next cycle; the whole region
// decode is a single combinational pass from the input ports into that
// register. A request is taken while a result waits, provided that result is
// being taken in the same cycle. Page register writes (modes 1 and 2) give a
// result with target "none" and take effect for the next request.
module paged_memory_map_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_address,
  input  logic        in_is_write,
  input  logic [7:0]  in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_target,
  output logic [16:0] out_location,
  output logic        out_write_taken,
  output logic [1:0]  out_controller_register
);
  import pmmd_pkg::*;

  `include "paged_memory_map_decoder_assert.svh"

  logic         in_acc;
  logic         out_valid_r;
  logic [3:0]   mem_page_r;
  logic [7:0]   win_page_r;
  pmmd_result_t res_r;
  pmmd_result_t dec_res;

  // The input waits only while a result is held back by the consumer.
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  pmmd_decode u_decode (
    .mode        (in_mode),
    .address     (in_address),
    .is_write    (in_is_write),
    .memory_page (mem_page_r),
    .window_page (win_page_r),
    .result      (dec_res)
  );

  // Page registers and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_page_r  <= '0;
      win_page_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc && in_mode == MODE_MEM_PG) begin
        mem_page_r <= in_data[7:4];
      end
      if (in_acc && in_mode == MODE_WIN_PG) begin
        win_page_r <= ~in_data;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload loads with each accepted request.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= dec_res;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_target              = res_r.target;
  assign out_location            = res_r.location;
  assign out_write_taken         = res_r.write_taken;
  assign out_controller_register = res_r.ctrl_reg;

  // A memory page write is visible in the page register on the next cycle.
  `PMMD_ASSERT_NEXT(a_mem_page_load, in_acc && in_mode == MODE_MEM_PG, mem_page_r == $past(in_data[7:4]))
  // Only RAM, controller and drive results may report a taken write.
  `PMMD_ASSERT_NOW(a_write_target, out_valid_r && res_r.write_taken, res_r.target == TGT_RAM || res_r.target == TGT_FDC || res_r.target == TGT_DRV)
  // Non-memory targets carry no location.
  `PMMD_ASSERT_NOW(a_loc_zero, out_valid_r && res_r.target != TGT_RAM && res_r.target != TGT_ROM, res_r.location == '0)
  // An empty output register never holds off the input.
  `PMMD_ASSERT_NOW(a_no_stall_empty, !out_valid_r, !in_stall)

endmodule
